@@ design/text_console_writer_defines.svh @@
// ---------------------------------------------------------------------------
// text_console_writer_defines.svh
// Assertion macros shared by the console writer checker.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent, outside reset.
`define TCW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw: same-cycle check failed");

// Check a consequent in the cycle after its antecedent, outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw: next-cycle check failed");

// Check what the ports show in the cycle after reset is applied.
`define TCW_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("tcw: reset check failed");

`endif

@@ design/tcw_pkg.sv @@
// ---------------------------------------------------------------------------
// tcw_pkg
// Geometry, field layout, codes and helper functions of the console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = ROWS * COLUMNS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int BOT_W    = $clog2(ROWS + 1);
  localparam int WIDE_W   = $clog2((ROWS + 32) * COLUMNS + 1) + 1;

  // Field widths
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int POS_W    = 12;
  localparam int CELL_W   = 16;
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int BYTE_W   = 8;

  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam logic [ROW_W-1:0] ROW_MAX = '1;
  localparam int HIDDEN_POS = ROWS * COLUMNS + COLUMNS;

  // Stream layout, lowest field first
  localparam int IN_CH_LSB    = 0;
  localparam int IN_IDX_LSB   = IN_CH_LSB + CHAR_W;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_POS_LSB  = 0;
  localparam int OUT_LO_LSB   = OUT_POS_LSB + POS_W;
  localparam int OUT_HI_LSB   = OUT_LO_LSB + BYTE_W;
  localparam int OUT_SC_BIT   = OUT_HI_LSB + BYTE_W;
  localparam int OUT_TDATA_W  = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;
  localparam logic [BYTE_W-1:0] CLEAR_ATTR    = 8'h0F;
  localparam int TAB_STEP = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCROLL_TOP    = 4'd0,
    REG_SCROLL_BOTTOM = 4'd1,
    REG_FOREGROUND    = 4'd2,
    REG_BACKGROUND    = 4'd3,
    REG_WRAP_DISABLED = 4'd4,
    REG_SCROLL_ENABLE = 4'd5,
    REG_BYTE_SWAP     = 4'd6,
    REG_CURSOR_HIDDEN = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [4:0] scroll_top;
    logic [4:0] scroll_bottom;
    logic [3:0] foreground;
    logic [3:0] background;
    logic       wrap_disabled;
    logic       scroll_enable;
    logic       byte_swap;
    logic       cursor_hidden;
  } cfg_t;

  // Outcome of one put command on cursor and cell store
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
    logic              scroll;
  } step_t;

  // Clamp the scroll bottom to 1..ROWS
  function automatic logic [BOT_W-1:0] eff_bottom(input logic [4:0] sb);
    logic [BOT_W-1:0] b;
    if (sb == 5'd0) begin
      b = BOT_W'(1);
    end else if (WIDE_W'(sb) > WIDE_W'(ROWS)) begin
      b = BOT_W'(ROWS);
    end else begin
      b = BOT_W'(sb);
    end
    return b;
  endfunction

  function automatic logic [WIDE_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return WIDE_W'(row) * WIDE_W'(COLUMNS) + WIDE_W'(col);
  endfunction

  function automatic logic [CELL_W-1:0] make_cell(input logic [BYTE_W-1:0] ch,
                                                  input logic [BYTE_W-1:0] attr,
                                                  input logic swap);
    return swap ? {ch, attr} : {attr, ch};
  endfunction

endpackage

@@ design/tcw_ram.sv @@
// ---------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tcw_step.sv @@
// ---------------------------------------------------------------------------
// tcw_step
// Character interpreter: cursor motion, cell write and scroll decision.
// ---------------------------------------------------------------------------
module tcw_step (
  input  tcw_pkg::cfg_t                 cfg,
  input  logic [tcw_pkg::COL_W-1:0]     col,
  input  logic [tcw_pkg::ROW_W-1:0]     row,
  input  logic [tcw_pkg::CHAR_W-1:0]    ch,
  output tcw_pkg::step_t                step
);
  import tcw_pkg::*;

  logic [COL_W-1:0]  col1;
  logic [ROW_W-1:0]  row1;
  logic [COL_W:0]    tab;
  logic [BYTE_W-1:0] attr;
  logic [BOT_W-1:0]  bot;
  logic              we;
  logic              scroll;

  assign attr = {cfg.background, cfg.foreground};
  assign bot  = eff_bottom(cfg.scroll_bottom);
  assign tab  = ({1'b0, col} + (COL_W + 1)'(TAB_STEP)) & ~(COL_W + 1)'(TAB_STEP - 1);

  // Interpret the byte, then, unless wrapping is disabled, wrap and check for scroll
  always_comb begin
    col1   = col;
    row1   = row;
    we     = 1'b0;
    scroll = 1'b0;
    case (ch)
      CH_BS: begin
        if (col != '0) col1 = col - 1'b1;
      end
      CH_TAB: begin
        col1 = (tab > {1'b0, COL_MAX}) ? COL_MAX : tab[COL_W-1:0];
      end
      CH_CR: begin
        col1 = '0;
      end
      CH_LF: begin
        if (row1 != ROW_MAX) row1 = row1 + 1'b1;
      end
      default: begin
        if (ch inside {[CH_SPACE:CH_PRINT_LAST]}) begin
          we = (WIDE_W'(col) < WIDE_W'(COLUMNS)) && (WIDE_W'(row) < WIDE_W'(ROWS));
          if (col != COL_MAX) col1 = col + 1'b1;
        end
      end
    endcase
    if (!cfg.wrap_disabled) begin
      if (WIDE_W'(col1) >= WIDE_W'(COLUMNS)) begin
        col1 = '0;
        if (row1 != ROW_MAX) row1 = row1 + 1'b1;
      end
      if ((WIDE_W'(row1) >= WIDE_W'(bot)) && cfg.scroll_enable) begin
        scroll = 1'b1;
      end
    end
  end

  assign step.col    = col1;
  assign step.row    = scroll ? ROW_W'(bot - 1'b1) : row1;
  assign step.we     = we;
  assign step.addr   = ADDR_W'(cell_addr(row, col));
  assign step.wdata  = make_cell(ch, attr, cfg.byte_swap);
  assign step.scroll = scroll;

endmodule

@@ design/text_console_writer.sv @@
// ---------------------------------------------------------------------------
// text_console_writer
// Text console: cell store with cursor, driven by put, clear and read beats.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one command beat; in_tuser is the command, in_tdata carries the
//           character byte and the cell index for a read.
//   out_* : one result beat per command: cursor position, read bytes and a
//           scroll flag. An output register holds it until out_tready.
//   cfg_* : register writes, always ready; write only while the block is idle.
// Timing: a beat is taken in the idle cycle and executed in the next one. Clear
//   walks the whole store. A put that scrolls first copies the rows of the scroll
//   region one row up, unless there are none to move, then blanks the bottom row;
//   rows move one cell per cycle through the RAM ports.
// Reset: the store is filled with blanks (0x0F20) in one pass over all cells;
//   in_tready stays low during it. Cursor and registers return to defaults.
// Stall: while out_tready is low the result waits in the output register; one
//   more command is taken and run, then in_tready stays low until it leaves.
// ---------------------------------------------------------------------------
module text_console_writer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // char_code[7:0], cell_index[18:8], zero pad
  input  logic [tcw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // cmd[1:0]
  input  logic [tcw_pkg::CMD_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cursor_position[11:0], read_low_byte[19:12], read_high_byte[27:20],
  // scrolled[28], zero pad
  output logic [tcw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tcw_pkg::*;

  typedef enum logic [5:0] {
    ST_FILL  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_COPY  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  localparam cfg_t CFG_RESET = '{
    scroll_top: 5'd0, scroll_bottom: 5'd25, foreground: 4'd15, background: 4'd0,
    wrap_disabled: 1'b0, scroll_enable: 1'b1, byte_swap: 1'b0, cursor_hidden: 1'b0
  };

  state_t             state_r, state_nxt;
  cfg_t               cfg_r, cfg_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [CHAR_W-1:0]  ch_r, ch_nxt;
  logic               idx_ok_r, idx_ok_nxt;
  logic [ADDR_W-1:0]  fill_addr_r, fill_addr_nxt;
  logic [ADDR_W-1:0]  fill_last_r, fill_last_nxt;
  logic [CELL_W-1:0]  fill_val_r, fill_val_nxt;
  logic               fill_report_r, fill_report_nxt;
  logic [ADDR_W-1:0]  copy_addr_r, copy_addr_nxt;
  logic [ADDR_W-1:0]  copy_last_r, copy_last_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic [BYTE_W-1:0]  res_lo_r, res_lo_nxt;
  logic [BYTE_W-1:0]  res_hi_r, res_hi_nxt;
  logic               res_sc_r, res_sc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  step_t              step;
  logic [IDX_W-1:0]   in_idx;
  logic               in_fire;
  logic               out_free;
  logic               load_out;
  logic [BOT_W-1:0]   bot;
  logic [WIDE_W-1:0]  src_first;
  logic [WIDE_W-1:0]  region_last;
  logic [WIDE_W-1:0]  blank_first;
  logic [WIDE_W-1:0]  top_next;
  logic [WIDE_W-1:0]  pos;

  assign in_idx    = in_tdata[IN_IDX_LSB +: IDX_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Scroll region bounds in cell addresses
  assign bot         = eff_bottom(cfg_r.scroll_bottom);
  assign top_next    = WIDE_W'(cfg_r.scroll_top) + 1'b1;
  assign src_first   = top_next * WIDE_W'(COLUMNS);
  assign region_last = WIDE_W'(bot) * WIDE_W'(COLUMNS) - 1'b1;
  assign blank_first = (WIDE_W'(bot) - 1'b1) * WIDE_W'(COLUMNS);

  tcw_step u_step (
    .cfg  (cfg_r),
    .col  (col_r),
    .row  (row_r),
    .ch   (ch_r),
    .step (step)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read the addressed cell at accept, the copy source during a scroll
  assign ram_raddr = (state_r == ST_COPY) ? copy_addr_r : ADDR_W'(in_idx);

  // Select the write source
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_addr_r;
    ram_wdata = fill_val_r;
    if (state_r == ST_FILL) begin
      ram_we = 1'b1;
    end else if (wr_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_r;
      ram_wdata = ram_rdata;
    end else if ((state_r == ST_EXEC) && (cmd_r == CMD_PUT)) begin
      ram_we    = step.we;
      ram_waddr = step.addr;
      ram_wdata = step.wdata;
    end
  end

  // Configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SCROLL_TOP:    cfg_nxt.scroll_top    = cfg_data[4:0];
        REG_SCROLL_BOTTOM: cfg_nxt.scroll_bottom = cfg_data[4:0];
        REG_FOREGROUND:    cfg_nxt.foreground    = cfg_data[3:0];
        REG_BACKGROUND:    cfg_nxt.background    = cfg_data[3:0];
        REG_WRAP_DISABLED: cfg_nxt.wrap_disabled = cfg_data[0];
        REG_SCROLL_ENABLE: cfg_nxt.scroll_enable = cfg_data[0];
        REG_BYTE_SWAP:     cfg_nxt.byte_swap     = cfg_data[0];
        REG_CURSOR_HIDDEN: cfg_nxt.cursor_hidden = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    cmd_nxt         = cmd_r;
    ch_nxt          = ch_r;
    idx_ok_nxt      = idx_ok_r;
    fill_addr_nxt   = fill_addr_r;
    fill_last_nxt   = fill_last_r;
    fill_val_nxt    = fill_val_r;
    fill_report_nxt = fill_report_r;
    copy_addr_nxt   = copy_addr_r;
    copy_last_nxt   = copy_last_r;
    wr_pend_nxt     = 1'b0;
    wr_addr_nxt     = wr_addr_r;
    res_lo_nxt      = res_lo_r;
    res_hi_nxt      = res_hi_r;
    res_sc_nxt      = res_sc_r;
    load_out        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt    = cmd_t'(in_tuser);
          ch_nxt     = in_tdata[IN_CH_LSB +: CHAR_W];
          idx_ok_nxt = WIDE_W'(in_idx) < WIDE_W'(CELLS);
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_lo_nxt = '0;
        res_hi_nxt = '0;
        res_sc_nxt = 1'b0;
        state_nxt  = ST_DONE;
        case (cmd_r)
          CMD_PUT: begin
            col_nxt = step.col;
            row_nxt = step.row;
            if (step.scroll) begin
              res_sc_nxt      = 1'b1;
              fill_addr_nxt   = ADDR_W'(blank_first);
              fill_last_nxt   = ADDR_W'(region_last);
              fill_val_nxt    = {cfg_r.background, cfg_r.foreground, CH_SPACE};
              fill_report_nxt = 1'b1;
              copy_addr_nxt   = ADDR_W'(src_first);
              copy_last_nxt   = ADDR_W'(region_last);
              state_nxt       = (top_next < WIDE_W'(bot)) ? ST_COPY : ST_FILL;
            end
          end
          CMD_CLEAR: begin
            col_nxt         = '0;
            row_nxt         = '0;
            fill_addr_nxt   = '0;
            fill_last_nxt   = ADDR_W'(CELLS - 1);
            fill_val_nxt    = make_cell(CH_SPACE, CLEAR_ATTR, cfg_r.byte_swap);
            fill_report_nxt = 1'b1;
            state_nxt       = ST_FILL;
          end
          CMD_READ: begin
            if (idx_ok_r) begin
              res_lo_nxt = ram_rdata[BYTE_W-1:0];
              res_hi_nxt = ram_rdata[CELL_W-1:BYTE_W];
            end
          end
          default: ;
        endcase
        // Finish at once when the output register is free
        if ((state_nxt == ST_DONE) && out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_COPY: begin
        // Read one cell ahead, write it one row up in the next cycle
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = copy_addr_r - ADDR_W'(COLUMNS);
        if (copy_addr_r == copy_last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          copy_addr_nxt = copy_addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (fill_addr_r == fill_last_r) begin
          state_nxt = fill_report_r ? ST_DONE : ST_IDLE;
        end else begin
          fill_addr_nxt = fill_addr_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result beat
  assign pos = cfg_r.cursor_hidden ? WIDE_W'(HIDDEN_POS) : cell_addr(row_nxt, col_nxt);

  always_comb begin
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (load_out) begin
      out_data_nxt                          = '0;
      out_data_nxt[OUT_POS_LSB +: POS_W]    = POS_W'(pos);
      out_data_nxt[OUT_LO_LSB +: BYTE_W]    = res_lo_nxt;
      out_data_nxt[OUT_HI_LSB +: BYTE_W]    = res_hi_nxt;
      out_data_nxt[OUT_SC_BIT]              = res_sc_nxt;
      out_valid_nxt                         = 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_FILL;
      cfg_r         <= CFG_RESET;
      col_r         <= '0;
      row_r         <= '0;
      fill_addr_r   <= '0;
      fill_last_r   <= ADDR_W'(CELLS - 1);
      fill_val_r    <= make_cell(CH_SPACE, CLEAR_ATTR, 1'b0);
      fill_report_r <= 1'b0;
      wr_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cfg_r         <= cfg_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      fill_addr_r   <= fill_addr_nxt;
      fill_last_r   <= fill_last_nxt;
      fill_val_r    <= fill_val_nxt;
      fill_report_r <= fill_report_nxt;
      wr_pend_r     <= wr_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ch_r        <= ch_nxt;
    idx_ok_r    <= idx_ok_nxt;
    copy_addr_r <= copy_addr_nxt;
    copy_last_r <= copy_last_nxt;
    wr_addr_r   <= wr_addr_nxt;
    res_lo_r    <= res_lo_nxt;
    res_hi_r    <= res_hi_nxt;
    res_sc_r    <= res_sc_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

@@ design/tcw_checker.sv @@
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the console writer, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module tcw_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tcw_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import tcw_pkg::*;

  logic scroll_beat;
  logic read_zero;

  assign scroll_beat = out_tvalid && out_tdata[OUT_SC_BIT];
  assign read_zero   = (out_tdata[OUT_LO_LSB +: BYTE_W] == '0) &&
                       (out_tdata[OUT_HI_LSB +: BYTE_W] == '0);

  // Reset starts the clearing pass with nothing offered
  `TCW_ASSERT_RESET(a_reset_quiet, !in_tready && !out_tvalid)
  // One command at a time: an accepted beat closes the input
  `TCW_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)
  // A stalled result holds
  `TCW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // A scroll comes only from a put, which reads nothing
  `TCW_ASSERT_SAME(a_scroll_no_read, scroll_beat, read_zero)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
